/* rtl/xbr_pkg.sv */
// Shared types and constants for the bounded xorshift random block.
// Holds the request and response item structs and the generator reset seed.
// No dependencies.
package xbr_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned COUNT_WIDTH = 5;

   localparam logic [WORD_WIDTH-1:0] SEED_RESET = 32'd2463534242;
   localparam logic [WORD_WIDTH-1:0] WORD_ONES = '1;

   localparam int unsigned SHIFT_A = 13;
   localparam int unsigned SHIFT_B = 17;
   localparam int unsigned SHIFT_C = 5;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] lower_bound;
      logic signed [WORD_WIDTH-1:0] upper_bound;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] random_value;
      logic                         bounds_error;
   } rsp_type;

endpackage

/* rtl/xorshift_bounded_random.sv */
// Bounded xorshift32 random source with rejection sampling over a signed range.
// Reversed bounds flag an error; a full 2^32 span adds the next word to the lower
// bound; otherwise two remainders run on one shared restoring divider and a new
// word is drawn for each rejected one. One item in flight; no request is taken
// until the result is in the output register. Reset (synchronous, active high)
// loads the generator reset seed; empties the output register. Depends on xbr_pkg.
module xorshift_bounded_random (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  xbr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output xbr_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [xbr_pkg::WORD_WIDTH-1:0] csr_write_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LIMIT = 5'b00010,
      ST_STEP  = 5'b00100,
      ST_MOD   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   function automatic logic [xbr_pkg::WORD_WIDTH-1:0] xorshift_next(
      input logic [xbr_pkg::WORD_WIDTH-1:0] w
   );
      logic [xbr_pkg::WORD_WIDTH-1:0] t;
      t = w ^ (w << xbr_pkg::SHIFT_A);
      t = t ^ (t >> xbr_pkg::SHIFT_B);
      t = t ^ (t << xbr_pkg::SHIFT_C);
      return t;
   endfunction

   state_type state_ff, state_in;

   logic [xbr_pkg::WORD_WIDTH-1:0]  gen_ff, gen_in;
   logic [xbr_pkg::WORD_WIDTH-1:0]  lower_ff, lower_in;
   logic [xbr_pkg::WORD_WIDTH-1:0]  span_ff, span_in;
   logic                            full_ff, full_in;
   logic [xbr_pkg::WORD_WIDTH-1:0]  limit_ff, limit_in;
   logic [xbr_pkg::WORD_WIDTH-1:0]  rem_ff, rem_in;
   logic [xbr_pkg::WORD_WIDTH-1:0]  quo_ff, quo_in;
   logic [xbr_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   xbr_pkg::rsp_type                res_ff, res_in;
   xbr_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [xbr_pkg::WORD_WIDTH:0]   trial;
   logic [xbr_pkg::WORD_WIDTH-1:0] diff;
   logic                           trial_ge;
   logic [xbr_pkg::WORD_WIDTH-1:0] rem_step;
   logic [xbr_pkg::WORD_WIDTH-1:0] gen_step;
   logic [xbr_pkg::WORD_WIDTH-1:0] req_span;
   logic                           div_last;
   logic                           out_free;

   assign trial    = {rem_ff, quo_ff[xbr_pkg::WORD_WIDTH-1]};
   assign diff     = trial[xbr_pkg::WORD_WIDTH-1:0] - span_ff;
   assign trial_ge = trial >= {1'b0, span_ff};
   assign rem_step = trial_ge ? diff : trial[xbr_pkg::WORD_WIDTH-1:0];
   assign gen_step = xorshift_next(gen_ff);
   assign req_span = req_data.upper_bound - req_data.lower_bound
                     + xbr_pkg::WORD_WIDTH'(1);
   assign div_last = count_ff == '1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      lower_in     = lower_ff;
      span_in      = span_ff;
      full_in      = full_ff;
      limit_in     = limit_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lower_in = req_data.lower_bound;
               span_in  = req_span;
               full_in  = req_span == '0;
               rem_in   = '0;
               quo_in   = xbr_pkg::WORD_ONES;
               count_in = '0;
               if (req_data.lower_bound > req_data.upper_bound) begin
                  res_in.random_value = '0;
                  res_in.bounds_error = 1'b1;
                  state_in = ST_DONE;
               end else if (req_span == '0) begin
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_LIMIT;
               end
            end
         end
         ST_LIMIT: begin
            rem_in   = rem_step;
            quo_in   = quo_ff << 1;
            count_in = count_ff + 1'b1;
            if (div_last) begin
               limit_in = ~rem_step;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            gen_in = gen_step;
            if (full_ff) begin
               res_in.random_value = lower_ff + gen_step;
               res_in.bounds_error = 1'b0;
               state_in = ST_DONE;
            end else if (gen_step < limit_ff) begin
               rem_in   = '0;
               quo_in   = gen_step;
               count_in = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            rem_in   = rem_step;
            quo_in   = quo_ff << 1;
            count_in = count_ff + 1'b1;
            if (div_last) begin
               res_in.random_value = lower_ff + rem_step;
               res_in.bounds_error = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         gen_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= xbr_pkg::SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lower_ff <= lower_in;
      span_ff  <= span_in;
      full_ff  <= full_in;
      limit_ff <= limit_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

endmodule
